// ----- design/fsa_pkg.sv -----
package fsa_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int IDX_W     = 5;
  localparam int GEN_W     = 20;
  localparam int DGEN_W    = 32;
  localparam int STAT_W    = 2;

  localparam logic [GEN_W-1:0] GEN_LIMIT_RST = 20'hFFFFF;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request beat, issue table reads
    logic commit;  // update state, write result register
  } fsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register holds an untaken beat
  } fsa_sts_t;

endpackage

// ----- design/fsa_ram.sv -----
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fsa_ctrl.sv -----
module fsa_ctrl import fsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  logic     res_ready_i,
  input  fsa_sts_t sts_i,
  output fsa_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // finish once the result register is free or drains this cycle
        if (!sts_i.out_busy || res_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/fsa_datapath.sv -----
module fsa_datapath import fsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsa_cmd_t          cmd_i,
  output fsa_sts_t          sts_o,
  input  logic              req_kind_i,
  input  logic [IDX_W-1:0]  req_idx_i,
  input  logic              req_used_i,
  input  logic              cfg_we_i,
  input  logic [GEN_W-1:0]  cfg_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [STAT_W-1:0] res_status_o,
  output logic [IDX_W-1:0]  res_slot_o,
  output logic [GEN_W-1:0]  res_fgen_o,
  output logic [DGEN_W-1:0] res_dgen_o,
  output logic              res_reopened_o,
  output logic [CNT_W-1:0]  res_in_use_o
);

  logic [GEN_W-1:0]     limit_q;
  logic [CNT_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     in_use_q, in_use_d;
  logic [NUM_SLOTS-1:0] alloc_q, alloc_d;
  logic [NUM_SLOTS-1:0] written_q, written_d;

  logic              op_kind_q;
  logic              op_used_q;
  logic              op_ok_q;
  logic [SLOT_W-1:0] op_addr_q;

  logic [SLOT_W-1:0] rd_addr;
  logic              rd_ok;
  logic              idx_in_range;

  logic [CNT_W-1:0]  link_rd, link_eff;
  logic [GEN_W-1:0]  gen_rd, gen_eff, gen_inc, gen_new;
  logic [DGEN_W-1:0] dgen_rd, dgen_eff, dgen_new;
  logic [GEN_W-1:0]  gen_sum;
  logic              tbl_we;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_d, status_q;
  logic [IDX_W-1:0]  slot_d, slot_q;
  logic [GEN_W-1:0]  fgen_d, fgen_q;
  logic [DGEN_W-1:0] dgen_d, dgen_q;
  logic              reopen_d, reopen_q;

  // request decode at accept
  assign idx_in_range = ({{(32-IDX_W){1'b0}}, req_idx_i} < NUM_SLOTS);
  assign rd_addr = (req_kind_i == KIND_FREE) ? req_idx_i[SLOT_W-1:0] : head_q[SLOT_W-1:0];
  assign rd_ok   = (req_kind_i == KIND_FREE) ? (idx_in_range && alloc_q[rd_addr])
                                             : (in_use_q != CNT_W'(NUM_SLOTS));

  // untouched entries read as their reset contents
  assign link_eff = written_q[op_addr_q] ? link_rd : CNT_W'(op_addr_q) + CNT_W'(1);
  assign gen_eff  = written_q[op_addr_q] ? gen_rd  : '0;
  assign dgen_eff = written_q[op_addr_q] ? dgen_rd : DGEN_W'(op_addr_q);

  assign gen_sum  = gen_eff + GEN_W'(1);
  assign gen_inc  = (gen_sum >= limit_q) ? '0 : gen_sum;
  assign gen_new  = op_used_q ? gen_inc : gen_eff;
  assign dgen_new = op_used_q ? dgen_eff + DGEN_W'(1) : dgen_eff;

  assign tbl_we = cmd_i.commit && op_ok_q && (op_kind_q == KIND_FREE);

  fsa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(op_addr_q),
    .wdata_i(head_q),
    .re_i   (cmd_i.load),
    .raddr_i(rd_addr),
    .rdata_o(link_rd)
  );

  fsa_ram #(.WIDTH(GEN_W), .DEPTH(NUM_SLOTS)) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(op_addr_q),
    .wdata_i(gen_new),
    .re_i   (cmd_i.load),
    .raddr_i(rd_addr),
    .rdata_o(gen_rd)
  );

  fsa_ram #(.WIDTH(DGEN_W), .DEPTH(NUM_SLOTS)) u_dgen_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(op_addr_q),
    .wdata_i(dgen_new),
    .re_i   (cmd_i.load),
    .raddr_i(rd_addr),
    .rdata_o(dgen_rd)
  );

  // commit: list update and result
  always_comb begin
    head_d    = head_q;
    in_use_d  = in_use_q;
    alloc_d   = alloc_q;
    written_d = written_q;
    status_d  = ST_OK;
    slot_d    = '0;
    fgen_d    = '0;
    dgen_d    = '0;
    reopen_d  = 1'b0;
    if (!op_ok_q) begin
      status_d = (op_kind_q == KIND_FREE) ? ST_BAD_FREE : ST_NO_SLOT;
    end else if (op_kind_q == KIND_ALLOC) begin
      head_d             = link_eff;
      in_use_d           = in_use_q + CNT_W'(1);
      alloc_d[op_addr_q] = 1'b1;
      slot_d             = IDX_W'(op_addr_q);
      fgen_d             = gen_eff;
      dgen_d             = dgen_eff;
    end else begin
      head_d               = CNT_W'(op_addr_q);
      in_use_d             = in_use_q - CNT_W'(1);
      alloc_d[op_addr_q]   = 1'b0;
      written_d[op_addr_q] = 1'b1;
      reopen_d             = (in_use_q == CNT_W'(NUM_SLOTS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= GEN_LIMIT_RST;
      head_q      <= '0;
      in_use_q    <= '0;
      alloc_q     <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        head_q      <= head_d;
        in_use_q    <= in_use_d;
        alloc_q     <= alloc_d;
        written_q   <= written_d;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_kind_q <= req_kind_i;
      op_used_q <= req_used_i;
      op_ok_q   <= rd_ok;
      op_addr_q <= rd_addr;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      fgen_q   <= fgen_d;
      dgen_q   <= dgen_d;
      reopen_q <= reopen_d;
    end
  end

  assign sts_o.out_busy = out_valid_q;
  assign res_valid_o    = out_valid_q;
  assign res_status_o   = status_q;
  assign res_slot_o     = slot_q;
  assign res_fgen_o     = fgen_q;
  assign res_dgen_o     = dgen_q;
  assign res_reopened_o = reopen_q;
  assign res_in_use_o   = in_use_q;

endmodule

// ----- design/flow_slot_allocator_with_generations.sv -----
// Flow slot allocator: LIFO free list of flow slots with per-slot flow and
// descriptor generations.
// Request channel (s_axis): tuser is the kind (allocate or free), tdata the
// slot to free and its was-used flag. Every request beat yields exactly one
// result beat on m_axis: tuser is the status, tdata the granted slot, its
// generations, the pool-reopened flag and the number of slots in use.
// cfg: a write beat sets the generation limit; write it only while idle.
// Timing: a request is taken in the idle state, where the tables are read (one
// registered read per table); the exec state then commits the list update and
// loads the result register once that register is free or drains. Result valid
// rises after the commit; no new request is taken before the last one commits.
// Stall: the result register holds its beat while m_axis_tready is low. The
// next request is still taken; it is held in the commit step until the
// result register drains.
// Reset: the list comes up with every slot free, head at slot 0, all flow
// generations zero and each descriptor generation equal to its slot index.
// Untouched table entries are supplied by per-slot written bits, so no
// clearing pass is needed; the block is ready right after reset.
module flow_slot_allocator_with_generations import fsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] slot_index, [5] was_used, [7:6] zero
  input  logic        s_axis_tuser,   // [0] kind
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [4:0] granted_slot, [24:5] flow_generation,
                                      // [56:25] descriptor_generation,
                                      // [57] pool_reopened, [63:58] slots_in_use
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // generation limit write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);

  fsa_cmd_t cmd;
  fsa_sts_t sts;

  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_slot;
  logic [GEN_W-1:0]  res_fgen;
  logic [DGEN_W-1:0] res_dgen;
  logic              res_reopened;
  logic [CNT_W-1:0]  res_in_use;

  // register write is always accepted
  assign cfg_ready_o = 1'b1;

  fsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .res_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_kind_i    (s_axis_tuser),
    .req_idx_i     (s_axis_tdata[4:0]),
    .req_used_i    (s_axis_tdata[5]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_status_o  (res_status),
    .res_slot_o    (res_slot),
    .res_fgen_o    (res_fgen),
    .res_dgen_o    (res_dgen),
    .res_reopened_o(res_reopened),
    .res_in_use_o  (res_in_use)
  );

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {res_in_use, res_reopened, res_dgen, res_fgen, res_slot};

endmodule
